// ----- rtl/hncc_pkg.sv -----
// ----------------------------------------------------------------------------
// hncc_pkg
// Shared types, constants and codes for the HSV nearest color classifier.
// ----------------------------------------------------------------------------
package hncc_pkg;

  // default table depth
  localparam int ENTRIES_DEF = 9;

  // field widths
  localparam int CH_W   = 16;
  localparam int HUE_W  = 12;
  localparam int IDX_W  = 4;
  localparam int DIST_W = 18;

  // hue arithmetic
  localparam int HUE_FULL       = 3600;
  localparam int HUE_SECTOR     = 600;
  localparam int HUE_GREEN_BASE = 1200;
  localparam int HUE_BLUE_BASE  = 2400;
  localparam int HUE_SUM_W      = 13;
  localparam int QUO_W          = 10;
  localparam int DIVIDEND_W     = 26;

  // match limit and no-match code
  localparam logic [DIST_W-1:0] LIMIT_RESET = 18'd20000;
  localparam logic [IDX_W-1:0]  NO_MATCH    = 4'd9;

  // item commands
  localparam logic CMD_CALIBRATE = 1'b0;
  localparam logic CMD_CLASSIFY  = 1'b1;

  // configuration port
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MATCH_LIMIT = 1'b0;

  // one table entry
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  sat;
    logic [CH_W-1:0]  val;
    logic [CH_W-1:0]  clr;
  } hsv_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DSTART,
    ST_DIV,
    ST_HUE,
    ST_CMD,
    ST_SCAN,
    ST_OUT
  } state_t;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // matcher control and status
  typedef struct packed {
    logic write_en;
    logic scan_start;
  } match_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } match_stat_t;

endpackage

// ----- rtl/hncc_in_if.sv -----
// ----------------------------------------------------------------------------
// hncc_in_if
// Input channel: one raw sensor reading with its command per transaction.
// ----------------------------------------------------------------------------
interface hncc_in_if;
  import hncc_pkg::*;

  logic            valid;
  logic            ready;
  logic            command;
  logic [IDX_W-1:0] entry_index;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic [CH_W-1:0] clear_light;

  modport source (
    output valid, command, entry_index, red, green, blue, clear_light,
    input  ready
  );

  modport sink (
    input  valid, command, entry_index, red, green, blue, clear_light,
    output ready
  );

endinterface

// ----- rtl/hncc_out_if.sv -----
// ----------------------------------------------------------------------------
// hncc_out_if
// Output channel: HSV tuple and classification result per transaction.
// ----------------------------------------------------------------------------
interface hncc_out_if;
  import hncc_pkg::*;

  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CH_W-1:0]   saturation;
  logic [CH_W-1:0]   brightness;
  logic [CH_W-1:0]   clear_out;
  logic [IDX_W-1:0]  class_index;
  logic [DIST_W-1:0] best_distance;

  modport source (
    output valid, hue, saturation, brightness, clear_out, class_index, best_distance,
    input  ready
  );

  modport sink (
    input  valid, hue, saturation, brightness, clear_out, class_index, best_distance,
    output ready
  );

endinterface

// ----- rtl/hncc_divider.sv -----
// ----------------------------------------------------------------------------
// hncc_divider
// Restoring divider for the hue sector: (600 * magnitude) / saturation,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hncc_divider
  import hncc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [CH_W-1:0]  numer_mag,
  input  logic [CH_W-1:0]  divisor,
  output div_stat_t        stat,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;
  logic [DIVIDEND_W-1:0] product;
  logic                  fits;

  // scaled dividend, at most 600 * 65535
  assign product = DIVIDEND_W'(numer_mag) * DIVIDEND_W'(HUE_SECTOR);
  assign fits    = (rem >= dvs);

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: compare, subtract and shift
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      rem      <= product;
      dvs      <= DIVIDEND_W'(divisor) << (QUO_W - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dvs;
      end
      quotient <= {quotient[QUO_W-2:0], fits};
      dvs      <= dvs >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/hncc_matcher.sv -----
// ----------------------------------------------------------------------------
// hncc_matcher
// Calibration table and sequential L1 nearest-entry scan, each entry as a
// distance step, then a compare step.
// ----------------------------------------------------------------------------
module hncc_matcher
  import hncc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  match_ctrl_t       ctrl,
  input  logic [IDX_W-1:0]  wr_index,
  input  hsv_t              cur,
  input  logic [DIST_W-1:0] limit,
  output match_stat_t       stat,
  output logic [IDX_W-1:0]  class_index,
  output logic [DIST_W-1:0] best_distance
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  hsv_t              entry_tab [ENTRIES];
  logic [CW-1:0]     cnt;
  logic              phase;
  logic              busy;
  logic              done;
  logic [DIST_W-1:0] entry_dist;
  logic [DIST_W-1:0] entry_dist_next;
  logic              wr_ok;
  hsv_t              rd;

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  assign wr_ok = ({1'b0, wr_index} < (IDX_W + 1)'(ENTRIES));
  assign rd    = entry_tab[cnt[IW-1:0]];

  // sum of absolute differences against the entry under the counter
  always_comb begin
    entry_dist_next = DIST_W'(abs_diff(CH_W'(cur.hue), CH_W'(rd.hue)))
                    + DIST_W'(abs_diff(cur.sat, rd.sat))
                    + DIST_W'(abs_diff(cur.val, rd.val))
                    + DIST_W'(abs_diff(cur.clr, rd.clr));
  end

  // table storage, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_tab[i] <= '0;
      end
    end else if (ctrl.write_en && wr_ok) begin
      entry_tab[wr_index[IW-1:0]] <= cur;
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.scan_start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          cnt <= cnt + 1'b1;
          if (cnt == CW'(ENTRIES - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  // distance register and running best, first lowest entry wins
  always_ff @(posedge clk) begin
    if (ctrl.scan_start) begin
      best_distance <= limit;
      class_index   <= NO_MATCH;
    end else if (busy) begin
      if (!phase) begin
        entry_dist <= entry_dist_next;
      end else if (entry_dist < best_distance) begin
        best_distance <= entry_dist;
        class_index   <= IDX_W'(cnt);
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/hsv_nearest_color_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// hsv_nearest_color_classifier_unit
// Raw RGB+clear reading to pseudo-HSV, calibration store and L1 classifier.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one reading per transaction: command (calibrate or
//   classify), entry_index, red, green, blue and clear_light. out_item
//   returns exactly one result per input transaction, in order. The APB
//   port holds match_limit at byte address 0 (reset 20000); pready is always
//   high. The user makes writes only while idle; the block does not check it.
// Timing:
//   one reading is in work at a time and in_item.ready is low meanwhile.
//   Each item passes through prep, divider start, the serial divide, hue
//   and command; a classify item then scans the table, and both end in
//   the output state. The next reading is taken only once the sequencer
//   is back in idle after the result loads.
//   The time is set by the 10-step serial hue divider and by the table
//   scan, which takes each entry as a distance step, then a compare step.
// Reset:
//   synchronous rst clears the sequencer, the output valid and every
//   calibration entry to zero, and restores match_limit.
// Stall:
//   a result waits in the output register while out_item.ready is low; one
//   more reading is accepted and held before its own output until it frees.
// ----------------------------------------------------------------------------
module hsv_nearest_color_classifier_unit
  import hncc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  hncc_in_if.sink           in_item,
  hncc_out_if.source        out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_t state;
  state_t state_next;

  // latched item
  logic             cmd;
  logic [IDX_W-1:0] idx;
  logic [CH_W-1:0]  r_in;
  logic [CH_W-1:0]  g_in;
  logic [CH_W-1:0]  b_in;
  logic [CH_W-1:0]  c_in;

  // prepared hsv terms
  hsv_t             cur;
  logic [CH_W-1:0]  num_mag;
  logic             num_neg;
  logic [HUE_W-1:0] hue_base;

  logic [DIST_W-1:0] match_limit;
  logic              cfg_write;

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [QUO_W-1:0] quotient;

  match_ctrl_t       match_ctrl;
  match_stat_t       match_stat;
  logic [IDX_W-1:0]  match_class;
  logic [DIST_W-1:0] match_best;

  logic accept;
  logic out_load;
  logic out_free;

  // combinational prep terms
  logic [CH_W-1:0]   mx;
  logic [CH_W-1:0]   mn;
  logic [CH_W:0]     diff;
  logic [HUE_W-1:0]  base_sel;
  logic [HUE_SUM_W-1:0] hue_sum;
  logic [HUE_SUM_W-1:0] hue_wrap;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_limit <= LIMIT_RESET;
    end else if (cfg_write && (paddr[ADDR_W-1:2] == REG_MATCH_LIMIT)) begin
      match_limit <= pwdata[DIST_W-1:0];
    end
  end

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_MATCH_LIMIT: prdata = DATA_W'(match_limit);
      default:         prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign accept   = in_item.valid && in_item.ready;
  assign out_free = !out_item.valid || out_item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_item.valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (div_stat.done) state_next = ST_HUE;
      ST_HUE:    state_next = ST_CMD;
      ST_CMD: begin
        if (cmd == CMD_CLASSIFY) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_SCAN:   if (match_stat.done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_item.ready         = 1'b0;
    div_ctrl.start        = 1'b0;
    match_ctrl.write_en   = 1'b0;
    match_ctrl.scan_start = 1'b0;
    out_load              = 1'b0;
    case (state)
      ST_IDLE:   in_item.ready = 1'b1;
      ST_DSTART: div_ctrl.start = 1'b1;
      ST_CMD: begin
        match_ctrl.write_en   = (cmd == CMD_CALIBRATE);
        match_ctrl.scan_start = (cmd == CMD_CLASSIFY);
      end
      ST_OUT:    out_load = out_free;
      default: ;
    endcase
  end

  // ---------------- item capture ----------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd  <= in_item.command;
      idx  <= in_item.entry_index;
      r_in <= in_item.red;
      g_in <= in_item.green;
      b_in <= in_item.blue;
      c_in <= in_item.clear_light;
    end
  end

  // ---------------- max, min and hue sector ----------------
  always_comb begin
    mx = (r_in > g_in) ? r_in : g_in;
    mn = (r_in < g_in) ? r_in : g_in;
    if (b_in > mx) mx = b_in;
    if (b_in < mn) mn = b_in;
    if (r_in == mx) begin
      diff     = {1'b0, g_in} - {1'b0, b_in};
      base_sel = HUE_W'(HUE_FULL);
    end else if (g_in == mx) begin
      diff     = {1'b0, b_in} - {1'b0, r_in};
      base_sel = HUE_W'(HUE_GREEN_BASE);
    end else begin
      diff     = {1'b0, r_in} - {1'b0, g_in};
      base_sel = HUE_W'(HUE_BLUE_BASE);
    end
  end

  // hsv tuple: sector terms at prep, hue once the quotient is ready
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      cur.val  <= mx;
      cur.sat  <= mx - mn;
      cur.clr  <= c_in;
      num_neg  <= diff[CH_W];
      num_mag  <= diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
      hue_base <= base_sel;
    end
    if (state == ST_HUE) begin
      cur.hue <= (cur.sat == '0) ? '0 : hue_wrap[HUE_W-1:0];
    end
  end

  // ---------------- hue from sector quotient ----------------
  always_comb begin
    if (num_neg) begin
      hue_sum = HUE_SUM_W'(hue_base) - HUE_SUM_W'(quotient);
    end else begin
      hue_sum = HUE_SUM_W'(hue_base) + HUE_SUM_W'(quotient);
    end
    if (hue_sum >= HUE_SUM_W'(HUE_FULL)) begin
      hue_wrap = hue_sum - HUE_SUM_W'(HUE_FULL);
    end else begin
      hue_wrap = hue_sum;
    end
  end

  // ---------------- shared units ----------------
  hncc_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .numer_mag (num_mag),
    .divisor   (cur.sat),
    .stat      (div_stat),
    .quotient  (quotient)
  );

  hncc_matcher #(
    .ENTRIES (ENTRIES)
  ) u_matcher (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (match_ctrl),
    .wr_index      (idx),
    .cur           (cur),
    .limit         (match_limit),
    .stat          (match_stat),
    .class_index   (match_class),
    .best_distance (match_best)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (out_load) begin
      out_item.valid <= 1'b1;
    end else if (out_item.ready) begin
      out_item.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.hue        <= cur.hue;
      out_item.saturation <= cur.sat;
      out_item.brightness <= cur.val;
      out_item.clear_out  <= cur.clr;
      if (cmd == CMD_CLASSIFY) begin
        out_item.class_index   <= match_class;
        out_item.best_distance <= match_best;
      end else begin
        out_item.class_index   <= NO_MATCH;
        out_item.best_distance <= '0;
      end
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsv_nearest_color_classifier_unit. A queue-fed
// driver offers sensor readings, a clocked monitor checks every result
// against an in-bench HSV converter and table matcher, and match_limit is
// reprogrammed over the APB port between phases of directed and random
// calibrate/classify traffic.
// ----------------------------------------------------------------------------
module tb
  import hncc_pkg::*;
();

  localparam int ENTRY_COUNT  = ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1450;
  localparam int PHASES       = 7;
  localparam int IDLE_PCT     = 22;
  localparam int HOLD_CYCLES  = 250;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTS   = 40;
  localparam int unsigned LIMIT_MAX = (1 << DIST_W) - 1;
  localparam logic [ADDR_W-1:0] ADDR_MATCH_LIMIT = ADDR_W'(REG_MATCH_LIMIT) << 2;
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = ADDR_W'(REG_MATCH_LIMIT + 1) << 2;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  clear_light;
  } reading_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CH_W-1:0]   saturation;
    logic [CH_W-1:0]   brightness;
    logic [CH_W-1:0]   clear_out;
    logic [IDX_W-1:0]  class_index;
    logic [DIST_W-1:0] best_distance;
  } color_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hncc_in_if  in_if ();
  hncc_out_if out_if ();

  hsv_nearest_color_classifier_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_if),
    .out_item (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // mirror of the calibration table and match limit
  hsv_t              cal_table [ENTRY_COUNT];
  logic [DIST_W-1:0] limit_copy;

  // readings last stored per entry, used to aim classify traffic
  reading_t stored_reading [ENTRY_COUNT];

  reading_t      pending_readings [$];
  color_result_t expected_results [$];

  int error_count;
  int cycle_count;
  int results_seen;
  int holds_done;
  int hold_left;
  int calibrate_count;
  int classify_count;
  int matched_count;
  int settings_used;
  bit steady_flow;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // pseudo-HSV of one raw reading
  function automatic hsv_t reading_hsv(input logic [CH_W-1:0] r, g, b, c);
    hsv_t p;
    int   mx;
    int   mn;
    int   num;
    int   base;
    int   h;
    mx = int'((r > g) ? r : g);
    mn = int'((r < g) ? r : g);
    if (int'(b) > mx) mx = int'(b);
    if (int'(b) < mn) mn = int'(b);
    p.val = mx[CH_W-1:0];
    p.sat = CH_W'(mx - mn);
    p.clr = c;
    if (mx == mn) begin
      p.hue = '0;
    end else begin
      if (int'(r) == mx) begin
        num  = int'(g) - int'(b);
        base = HUE_FULL;
      end else if (int'(g) == mx) begin
        num  = int'(b) - int'(r);
        base = HUE_GREEN_BASE;
      end else begin
        num  = int'(r) - int'(g);
        base = HUE_BLUE_BASE;
      end
      // signed division truncates toward zero
      h = (base + (HUE_SECTOR * num) / (mx - mn)) % HUE_FULL;
      p.hue = h[HUE_W-1:0];
    end
    return p;
  endfunction

  function automatic int unsigned gap(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  // store or classify one reading and return the result it must produce
  function automatic color_result_t apply_reading(input reading_t rd);
    color_result_t res;
    hsv_t          p;
    int unsigned   d;
    int unsigned   best;
    int            i;
    p = reading_hsv(rd.red, rd.green, rd.blue, rd.clear_light);
    res.class_index = NO_MATCH;
    if (rd.command == CMD_CALIBRATE) begin
      if (rd.entry_index < ENTRY_COUNT) cal_table[rd.entry_index] = p;
      best = 0;
    end else begin
      best = 32'(limit_copy);
      for (i = 0; i < ENTRY_COUNT; i++) begin
        d = gap(32'(p.hue), 32'(cal_table[i].hue)) + gap(32'(p.sat), 32'(cal_table[i].sat))
          + gap(32'(p.val), 32'(cal_table[i].val)) + gap(32'(p.clr), 32'(cal_table[i].clr));
        // strict compare keeps the lowest entry on a tie
        if (d < best) begin
          best            = d;
          res.class_index = IDX_W'(i);
        end
      end
    end
    res.hue           = p.hue;
    res.saturation    = p.sat;
    res.brightness    = p.val;
    res.clear_out     = p.clr;
    res.best_distance = best[DIST_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] mismatch, result %0d: %s got %0d expected %0d",
               $realtime, results_seen, what, got, want);
  endtask

  // input driver
  always @(posedge clk) begin
    reading_t      nxt;
    color_result_t pred;
    if (rst) begin
      in_if.valid <= 1'b0;
    end else begin
      // accepted transaction: predict its result
      if (in_if.valid && in_if.ready) begin
        pred = apply_reading({in_if.command, in_if.entry_index, in_if.red,
                              in_if.green, in_if.blue, in_if.clear_light});
        expected_results.push_back(pred);
        if (in_if.command == CMD_CALIBRATE) begin
          calibrate_count++;
        end else begin
          classify_count++;
          if (pred.class_index != NO_MATCH) matched_count++;
        end
      end
      // offer the next reading or idle
      if (!in_if.valid || in_if.ready) begin
        if (pending_readings.size() != 0 &&
            (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_readings.pop_front();
          in_if.valid       <= 1'b1;
          in_if.command     <= nxt.command;
          in_if.entry_index <= nxt.entry_index;
          in_if.red         <= nxt.red;
          in_if.green       <= nxt.green;
          in_if.blue        <= nxt.blue;
          in_if.clear_light <= nxt.clear_light;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && results_seen == 400) ||
                 (holds_done == 1 && results_seen == 1000)) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    color_result_t got;
    color_result_t want;
    if (rst) begin
      out_if.ready <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.hue, out_if.saturation, out_if.brightness, out_if.clear_out,
               out_if.class_index, out_if.best_distance};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, hue", 32'(got.hue), 0);
        end else begin
          want = expected_results.pop_front();
          if (got.hue != want.hue)
            report_mismatch("hue", 32'(got.hue), 32'(want.hue));
          if (got.saturation != want.saturation)
            report_mismatch("saturation", 32'(got.saturation), 32'(want.saturation));
          if (got.brightness != want.brightness)
            report_mismatch("brightness", 32'(got.brightness), 32'(want.brightness));
          if (got.clear_out != want.clear_out)
            report_mismatch("clear_out", 32'(got.clear_out), 32'(want.clear_out));
          if (got.class_index != want.class_index)
            report_mismatch("class_index", 32'(got.class_index), 32'(want.class_index));
          if (got.best_distance != want.best_distance)
            report_mismatch("best_distance", 32'(got.best_distance),
                            32'(want.best_distance));
        end
        results_seen <= results_seen + 1;
      end
      out_if.ready <= (hold_left == 0) && (steady_flow || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // apb write: setup then access, register updates at the access edge
  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // read match_limit back and compare with the mirror
  task automatic check_limit_readback();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MATCH_LIMIT;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata != DATA_W'(limit_copy))
      report_mismatch("match_limit readback", prdata, 32'(limit_copy));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limit(input int unsigned lim);
    logic [DATA_W-1:0] data;
    // junk in the unused upper bits must be dropped
    data = ($urandom() & ~DATA_W'(LIMIT_MAX)) | DATA_W'(lim);
    apb_write(ADDR_MATCH_LIMIT, data);
    limit_copy = data[DIST_W-1:0];
    settings_used++;
    check_limit_readback();
  endtask

  // wait until every offered reading has produced its result
  task automatic wait_drain();
    do @(posedge clk);
    while (pending_readings.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_reading(input logic cmd, input int unsigned idx,
                              input int unsigned r, input int unsigned g,
                              input int unsigned b, input int unsigned c);
    reading_t rd;
    rd = {cmd, IDX_W'(idx), CH_W'(r), CH_W'(g), CH_W'(b), CH_W'(c)};
    if (cmd == CMD_CALIBRATE && idx < ENTRY_COUNT) stored_reading[idx] = rd;
    pending_readings.push_back(rd);
  endtask

  function automatic int unsigned nudge(input int unsigned x, input int unsigned spread);
    int v;
    v = int'(x) + int'($urandom_range(2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // random colour: wide, dim, very dim or nearly gray
  function automatic reading_t random_color();
    reading_t    rd;
    int unsigned span;
    int unsigned shade;
    rd.command     = 1'($urandom_range(1));
    rd.entry_index = IDX_W'($urandom_range((1 << IDX_W) - 1));
    rd.clear_light = CH_W'($urandom_range(65535));
    case ($urandom_range(3))
      0: span = 65535;
      1: span = 1023;
      2: span = 15;
      default: span = 0;
    endcase
    if (span != 0) begin
      rd.red   = CH_W'($urandom_range(span));
      rd.green = CH_W'($urandom_range(span));
      rd.blue  = CH_W'($urandom_range(span));
    end else begin
      shade    = $urandom_range(65535 - 3);
      rd.red   = CH_W'(shade + $urandom_range(3));
      rd.green = CH_W'(shade + $urandom_range(3));
      rd.blue  = CH_W'(shade + $urandom_range(3));
    end
    return rd;
  endfunction

  // mostly calibrate-then-classify-nearby traffic, some pure noise
  task automatic push_random_reading();
    reading_t    rd;
    int unsigned k;
    int unsigned roll;
    int unsigned spread;
    k    = $urandom_range(ENTRY_COUNT - 1);
    roll = $urandom_range(99);
    if (roll < 20) begin
      rd = random_color();
      push_reading(CMD_CALIBRATE, k, 32'(rd.red), 32'(rd.green), 32'(rd.blue),
                   32'(rd.clear_light));
    end else if (roll < 75) begin
      case ($urandom_range(3))
        0: spread = 0;
        1: spread = 20;
        2: spread = 300;
        default: spread = 3000;
      endcase
      rd = stored_reading[k];
      push_reading(CMD_CLASSIFY, $urandom_range((1 << IDX_W) - 1),
                   nudge(32'(rd.red), spread), nudge(32'(rd.green), spread),
                   nudge(32'(rd.blue), spread), nudge(32'(rd.clear_light), spread));
    end else begin
      rd = random_color();
      push_reading(rd.command, 32'(rd.entry_index), 32'(rd.red), 32'(rd.green),
                   32'(rd.blue), 32'(rd.clear_light));
    end
  endtask

  // stimulus and phase control
  initial begin
    int unsigned lim;
    int          ph;
    int          n;
    clk               = 1'b0;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_CALIBRATE;
    in_if.entry_index = '0;
    in_if.red         = '0;
    in_if.green       = '0;
    in_if.blue        = '0;
    in_if.clear_light = '0;
    out_if.ready      = 1'b0;
    steady_flow       = 1'b0;
    error_count       = 0;
    cycle_count       = 0;
    calibrate_count   = 0;
    classify_count    = 0;
    matched_count     = 0;
    settings_used     = 0;
    limit_copy        = LIMIT_RESET;
    for (n = 0; n < ENTRY_COUNT; n++) begin
      cal_table[n]      = '0;
      stored_reading[n] = '0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset value, then a write to an unmapped register must change nothing
    check_limit_readback();
    apb_write(ADDR_UNMAPPED, $urandom());
    check_limit_readback();

    // directed: cleared table, hue sectors and wrap, ties, unused entries
    push_reading(CMD_CLASSIFY,   0, 0, 0, 0, 0);
    push_reading(CMD_CLASSIFY,  15, 65535, 65535, 65535, 65535);
    push_reading(CMD_CALIBRATE,  0, 65535, 0, 0, 65535);
    push_reading(CMD_CALIBRATE,  1, 0, 65535, 0, 0);
    push_reading(CMD_CALIBRATE,  2, 0, 0, 65535, 1234);
    push_reading(CMD_CALIBRATE,  3, 1000, 200, 900, 500);
    push_reading(CMD_CALIBRATE,  4, 1000, 200, 900, 500);
    push_reading(CMD_CLASSIFY,   7, 1000, 200, 900, 500);
    push_reading(CMD_CALIBRATE,  5, 777, 777, 777, 4000);
    push_reading(CMD_CALIBRATE,  6, 5000, 5000, 100, 0);
    push_reading(CMD_CALIBRATE,  7, 10, 3000, 3000, 65535);
    push_reading(CMD_CALIBRATE,  8, 65535, 65535, 65535, 0);
    push_reading(CMD_CALIBRATE,  9, 1, 2, 3, 4);
    push_reading(CMD_CALIBRATE, 15, 65535, 65535, 0, 65535);
    push_reading(CMD_CLASSIFY,   0, 0, 0, 0, 0);
    push_reading(CMD_CLASSIFY,   1, 65535, 0, 0, 65535);
    push_reading(CMD_CLASSIFY,   2, 10, 3001, 2999, 65530);
    push_reading(CMD_CLASSIFY,   9, 1, 2, 3, 4);
    push_reading(CMD_CLASSIFY,  15, 65535, 65535, 0, 65535);
    push_reading(CMD_CLASSIFY,   3, 0, 65535, 65535, 0);
    push_reading(CMD_CLASSIFY,   8, 12345, 54321, 1111, 22222);
    wait_drain();

    // random phases, each under its own match limit
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: lim = LIMIT_MAX;
        1: lim = 0;
        2: lim = 1;
        4: lim = 3000;
        5: lim = 32'(LIMIT_RESET);
        default: lim = $urandom_range(LIMIT_MAX - 1, 2);
      endcase
      set_limit(lim);
      steady_flow <= (ph == 3);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) push_random_reading();
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d calibrate and %0d classify readings, %0d matched an entry,",
             calibrate_count, classify_count, matched_count);
    $display("across %0d match-limit settings and %0d receiver hold-offs",
             settings_used + 1, holds_done);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hncc_pkg.sv
rtl/hncc_in_if.sv
rtl/hncc_out_if.sv
rtl/hncc_divider.sv
rtl/hncc_matcher.sv
rtl/hsv_nearest_color_classifier_unit.sv
tb/sv/tb.sv
